// ===== hw/rtl/rational_arithmetic_reduce_defines.svh =====
// Assertion macros shared by the RTL
`ifndef RATIONAL_ARITHMETIC_REDUCE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_REDUCE_DEFINES_SVH
// Implication checked every cycle outside reset
`define RAR_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define RAR_ASSERT_NXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg
// Types and codes shared by the rational arithmetic reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;
  localparam int NUM_BITS = 33;
  localparam int DEN_BITS = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD_INIT,
    ST_GCD,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic comb;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } sts_t;
endpackage

// ===== hw/rtl/rational_arithmetic_reduce.sv =====
// A zero or undefined result skips the GCD and the dividers and goes straight to output;
// any other result passes the multiply, combine, binary GCD and divide states in order.
// The binary GCD loop (one step a cycle) feeds the bit-serial dividers; one item in flight.
// A new item is taken while the previous result waits in the output register.
// Reset (rst, synchronous) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce
// Fraction add/sub/mul/div with reduction to lowest terms.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_reduce_defines.svh"
module rational_arithmetic_reduce #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         operation,
  input  logic signed [OPERAND_BITS-1:0]     a_num,
  input  logic signed [OPERAND_BITS-1:0]     a_den,
  input  logic signed [OPERAND_BITS-1:0]     b_num,
  input  logic signed [OPERAND_BITS-1:0]     b_den,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rar_pkg::NUM_BITS-1:0] res_num,
  output logic [rar_pkg::DEN_BITS-1:0]       res_den,
  output logic                               zero_den_error
);
  import rar_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic in_fire;
  logic out_busy;

  assign in_ready = idle;
  assign in_fire = in_valid && in_ready;
  // a finished beat can be loaded only once the prior beat is taken or is leaving
  assign out_busy = out_valid && !out_ready;

  rar_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_busy),
    .sts(sts), .cmd(cmd), .idle(idle)
  );

  rar_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .operation(operation),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .sts(sts), .res_num(res_num), .res_den(res_den),
    .zero_den_error(zero_den_error)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  `RAR_ASSERT_NXT(a_finish_valid, clk, rst, cmd.finish, out_valid)
  `RAR_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.finish, !(out_valid && !out_ready))
  `RAR_ASSERT_IMP(a_load_idle, clk, rst, cmd.load, idle)
endmodule

// ===== hw/rtl/rar_ctrl.sv =====
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer: multiply, combine, binary GCD, two serial divides, output.
// ----------------------------------------------------------------------------
module rar_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_busy,
  input  rar_pkg::sts_t sts,
  output rar_pkg::cmd_t cmd,
  output logic          idle
);
  import rar_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = ST_COMB;
      end
      ST_COMB: begin
        cmd.comb = 1'b1;
        state_next = ST_GCD_INIT;
      end
      ST_GCD_INIT: begin
        if (sts.special) state_next = ST_OUT;
        else begin
          cmd.gcd_init = 1'b1;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts.gcd_done) state_next = ST_DIV_INIT;
        else cmd.gcd_step = 1'b1;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_next = ST_OUT;
        else cmd.div_step = 1'b1;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/rar_dp.sv =====
// ----------------------------------------------------------------------------
// rar_dp
// Datapath: sign/magnitude products, binary GCD, restoring dividers.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_reduce_defines.svh"
module rar_dp #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rar_pkg::cmd_t                    cmd,
  input  logic [1:0]                       operation,
  input  logic signed [OPERAND_BITS-1:0]   a_num,
  input  logic signed [OPERAND_BITS-1:0]   a_den,
  input  logic signed [OPERAND_BITS-1:0]   b_num,
  input  logic signed [OPERAND_BITS-1:0]   b_den,
  output rar_pkg::sts_t                    sts,
  output logic signed [rar_pkg::NUM_BITS-1:0] res_num,
  output logic [rar_pkg::DEN_BITS-1:0]     res_den,
  output logic                             zero_den_error
);
  import rar_pkg::*;

  localparam int OB = OPERAND_BITS;
  localparam int PB = 2 * OB;       // product magnitude
  localparam int MB = PB + 1;       // sum magnitude
  localparam int CW = $clog2(MB + 1);

  logic [1:0]    op;
  logic [OB-1:0] m_an, m_ad, m_bn, m_bd;
  logic          s_an, s_ad, s_bn, s_bd;
  logic [PB-1:0] p0, p1, pd;
  logic          p0n, p1n, pdn;
  logic [MB-1:0] nmag, dmag;
  logic          neg;
  logic [MB-1:0] gx, gy;
  logic [CW-1:0] shf;
  logic [MB-1:0] g;
  logic [MB-1:0] qn, qd, rn, rd;
  logic [CW-1:0] cnt;

  function automatic logic [OB-1:0] mag_of(input logic [OB-1:0] v);
    mag_of = v[OB-1] ? (~v + 1'b1) : v;
  endfunction

  // serial operands: first mul pass forms product 0, second product 1 and the denominator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      m_an <= mag_of(a_num); s_an <= a_num[OB-1];
      m_ad <= mag_of(a_den); s_ad <= a_den[OB-1];
      m_bn <= mag_of(b_num); s_bn <= b_num[OB-1];
      m_bd <= mag_of(b_den); s_bd <= b_den[OB-1];
    end
    if (cmd.mul1) begin
      unique case (op_t'(op))
        OP_ADD, OP_SUB: begin
          p0 <= m_an * m_bd; p0n <= s_an ^ s_bd;
        end
        OP_MUL: begin
          p0 <= m_an * m_bn; p0n <= s_an ^ s_bn;
        end
        default: begin
          p0 <= m_an * m_bd; p0n <= s_an ^ s_bd;
        end
      endcase
    end
    if (cmd.mul2) begin
      p1 <= m_ad * m_bn;
      p1n <= s_ad ^ s_bn ^ (op == OP_SUB);
      if (op == OP_DIV) begin
        pd <= m_ad * m_bn; pdn <= s_ad ^ s_bn;
      end else begin
        pd <= m_ad * m_bd; pdn <= s_ad ^ s_bd;
      end
    end
    if (cmd.comb) begin
      dmag <= {1'b0, pd};
      if (op == OP_ADD || op == OP_SUB) begin
        if (p0n == p1n) begin
          nmag <= {1'b0, p0} + {1'b0, p1}; neg <= p0n ^ pdn;
        end else if (p0 >= p1) begin
          nmag <= {1'b0, p0 - p1}; neg <= p0n ^ pdn;
        end else begin
          nmag <= {1'b0, p1 - p0}; neg <= p1n ^ pdn;
        end
      end else begin
        nmag <= {1'b0, p0}; neg <= p0n ^ pdn;
      end
    end
  end

  assign sts.special = (dmag == '0) || (nmag == '0);
  assign sts.gcd_done = (gy == '0);
  assign sts.div_done = (cnt == '0);

  // binary GCD; shf counts common factors of two, gy reaches zero at the end
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      gx <= nmag; gy <= dmag; shf <= '0;
    end else if (cmd.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1; gy <= gy >> 1; shf <= shf + 1'b1;
      end else if (!gx[0]) gx <= gx >> 1;
      else if (!gy[0]) gy <= gy >> 1;
      else if (gx >= gy) begin
        // both odd: keep the smaller in gx, halved difference in gy
        gx <= gy; gy <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
  end

  // two restoring dividers sharing a bit counter
  logic [MB:0] tn, td;
  assign tn = {rn, qn[MB-1]} - {1'b0, g};
  assign td = {rd, qd[MB-1]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      g <= gx << shf;
      qn <= nmag; qd <= dmag; rn <= '0; rd <= '0;
      cnt <= CW'(MB);
    end else if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
      if (!tn[MB]) begin
        rn <= tn[MB-1:0]; qn <= {qn[MB-2:0], 1'b1};
      end else begin
        rn <= {rn[MB-2:0], qn[MB-1]}; qn <= {qn[MB-2:0], 1'b0};
      end
      if (!td[MB]) begin
        rd <= td[MB-1:0]; qd <= {qd[MB-2:0], 1'b1};
      end else begin
        rd <= {rd[MB-2:0], qd[MB-1]}; qd <= {qd[MB-2:0], 1'b0};
      end
    end
  end

  // result register
  logic [MB:0] qn_x, nres;
  assign qn_x = {1'b0, qn};
  assign nres = neg ? (~qn_x + 1'b1) : qn_x;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (dmag == '0) begin
        res_num <= '0; res_den <= DEN_BITS'(1); zero_den_error <= 1'b1;
      end else if (nmag == '0) begin
        res_num <= '0; res_den <= DEN_BITS'(1); zero_den_error <= 1'b0;
      end else begin
        res_num <= NUM_BITS'(nres);
        res_den <= DEN_BITS'(qd);
        zero_den_error <= 1'b0;
      end
    end
  end

  `RAR_ASSERT_IMP(a_div_nonzero, clk, rst, cmd.div_init, gx != '0)
  `RAR_ASSERT_NXT(a_cnt_load, clk, rst, cmd.div_init, cnt == CW'(MB))
  `RAR_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1,
                  $onehot0({cmd.gcd_init, cmd.gcd_step, cmd.div_init, cmd.div_step}))
endmodule

// ===== dv/rational_arithmetic_reduce_checker.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce_checker
// Watches both channels, predicts each reduced fraction and compares beats.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce_checker
  import rar_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic signed [15:0]         a_num,
  input  logic signed [15:0]         a_den,
  input  logic signed [15:0]         b_num,
  input  logic signed [15:0]         b_den,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [NUM_BITS-1:0] res_num,
  input  logic [DEN_BITS-1:0]        res_den,
  input  logic                       zero_den_error,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic signed [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0]        den;
    logic                       err;
  } frac_t;

  frac_t reduced_q[$];

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Signed 64-bit math is exact here: cross products stay under 2^32.
  function automatic frac_t reduce_frac(op_t op, longint an, longint ad,
                                        longint bn, longint bd);
    longint n, d;
    longint unsigned nm, dm, g;
    frac_t r;
    case (op)
      OP_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
      OP_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
      OP_MUL: begin n = an * bn; d = ad * bd; end
      default: begin n = an * bd; d = ad * bn; end
    endcase
    r = '{num: '0, den: 1, err: 1'b0};
    if (d == 0) begin
      r.err = 1'b1;
    end else if (n != 0) begin
      nm = (n < 0) ? -n : n;
      dm = (d < 0) ? -d : d;
      g = gcd_of(nm, dm);
      nm = nm / g;
      r.den = DEN_BITS'(dm / g);
      r.num = ((n < 0) != (d < 0)) ? -NUM_BITS'(nm) : NUM_BITS'(nm);
    end
    return r;
  endfunction

  assign pending = reduced_q.size();

  always @(posedge clk) begin
    frac_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        reduced_q.push_back(reduce_frac(op_t'(operation), a_num, a_den, b_num, b_den));
      if (out_valid && out_ready) begin
        if (reduced_q.size() == 0) begin
          $display("%0t: unexpected beat %0d/%0d err %0b", $time, res_num, res_den,
                   zero_den_error);
          fail_count <= fail_count + 1;
        end else begin
          want = reduced_q.pop_front();
          if (want.num !== res_num || want.den !== res_den || want.err !== zero_den_error) begin
            $display("%0t: expected %0d/%0d err %0b, actual %0d/%0d err %0b", $time,
                     want.num, want.den, want.err, res_num, res_den, zero_den_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/rational_arithmetic_reduce_test.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce_test
// Drives directed and random fraction beats with random idling and a long
// output hold-off; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce_test;
  import rar_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = OP_ADD;
  logic signed [15:0] a_num = '0, a_den = 16'sd1, b_num = '0, b_den = 16'sd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NUM_BITS-1:0] res_num;
  logic [DEN_BITS-1:0] res_den;
  logic zero_den_error;
  int fail_count, pending;

  // idle percentages per phase; hold_off forces a long receiver stall
  int send_idle = 25, recv_idle = 83;
  int hold_off = 0;

  rational_arithmetic_reduce #(.OPERAND_BITS(16)) u_top (.*);

  rational_arithmetic_reduce_checker u_chk (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stall, or held off while hold_off counts down.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Random 16-bit operand biased toward extremes, zero and small values.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return 16'($signed($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  // Holds one beat until accepted; random idle first. Valid stays high on
  // return so the next beat can follow back to back.
  task automatic send_beat(op_t op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      logic [15:0] ad, bd;
      // mostly nonzero denominators; the zero case stays reachable
      ad = pick_operand();
      bd = pick_operand();
      if (ad == 0 && $urandom_range(3) != 0) ad = 16'd3;
      if (bd == 0 && $urandom_range(3) != 0) bd = 16'd7;
      send_beat(op_t'($urandom_range(3)), pick_operand(), ad, pick_operand(), bd);
    end
  endtask

  initial begin
    op_t op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each op on extremes, zero results and zero denominators
    for (int k = 0; k < 4; k++) begin
      op = op_t'(k);
      send_beat(op, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
      send_beat(op, 16'h7fff, 16'h0001, 16'h8000, 16'hffff);
      send_beat(op, 16'd0, 16'd5, 16'd0, 16'd9);
      send_beat(op, 16'd3, 16'd0, 16'd2, 16'd4);
      send_beat(op, 16'hfffe, 16'd4, 16'd6, 16'hfff7);
    end
    send_beat(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_beat(OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);

    send_random(130);
    // stall the receiver while beats keep coming so the block backs up
    hold_off <= 400;
    send_random(10);

    send_idle = 83; recv_idle = 25;
    send_random(130);
    send_idle = 0; recv_idle = 0;
    send_random(130);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule
